/* src/prb_pkg.sv */
// Shared types, sizes and helpers for the packet ring buffer.
// Depends on nothing; every other file of the block but prb_ram uses it.
`timescale 1ns / 1ps

package prb_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_BYTES = 2048;

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int IDX_W     = $clog2(SLOT_BYTES);
    localparam int CNT_W     = $clog2(SLOT_BYTES + 1);
    localparam int LIM_W     = 12;
    localparam int CMP_W     = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int PAY_AW    = SLOT_W + IDX_W;
    localparam int PAY_DEPTH = SLOTS << IDX_W;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    localparam logic STATUS_EMPTY = 1'b0;
    localparam logic STATUS_VALID = 1'b1;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       byte_value;
        logic             last_byte;
        logic [LIM_W-1:0] read_limit;
    } item_t;

    typedef struct packed {
        logic       status;
        logic [7:0] out_byte;
        logic       end_of_packet;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [PAY_AW-1:0] addr;
        logic [7:0]        data;
    } pay_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [CNT_W-1:0]  data;
    } len_wr_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } rd_stat_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(SLOTS - 1))
            r = '0;
        else
            r = s + 1'b1;
        return r;
    endfunction

endpackage

/* src/prb_channels.sv */
// Valid/ready channel interfaces for the item and result sides.
// Depends on prb_pkg for the payload structs.
`timescale 1ns / 1ps

interface prb_item_if;
    logic          valid;
    logic          ready;
    prb_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prb_result_if;
    logic             valid;
    logic             ready;
    prb_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/packet_ring_buffer.sv */
// Push beats: one per cycle unless a pop is pending; written to payload memory when taken.
// Pop beats: acceptance sets a pending flag that loads the result into the output
// register; while pending, all items wait, as the payload memory read is registered.
// A push is taken while a result waits; a pop waits for the output register to free.
// Reset clears the slot pointers and counters at once; the memories are not cleared.
`timescale 1ns / 1ps

module packet_ring_buffer (
    input logic          clk,
    input logic          rst_n,
    prb_item_if.sink     item,
    prb_result_if.source result
);
    import prb_pkg::*;

    logic              accept, push_fire, pop_fire;
    logic [SLOT_W-1:0] head, tail;
    pay_wr_t           pay_wr;
    len_wr_t           len_wr;
    logic [PAY_AW-1:0] pay_raddr;
    logic [SLOT_W-1:0] len_raddr;
    logic [7:0]        pay_rdata;
    logic [CNT_W-1:0]  len_rdata;
    rd_stat_t          stat;

    // Items wait while a pop is in flight; pops also wait while the output is stalled.
    assign item.ready = !stat.busy && ((item.data.kind == KIND_PUSH) || !stat.out_full);
    assign accept     = item.valid && item.ready;
    assign push_fire  = accept && (item.data.kind == KIND_PUSH);
    assign pop_fire   = accept && (item.data.kind == KIND_POP);

    prb_wr_ctrl u_wr (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_fire  (push_fire),
        .byte_value (item.data.byte_value),
        .last_byte  (item.data.last_byte),
        .tail       (tail),
        .head       (head),
        .pay_wr     (pay_wr),
        .len_wr     (len_wr)
    );

    prb_rd_ctrl u_rd (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_fire   (pop_fire),
        .read_limit (item.data.read_limit),
        .head       (head),
        .tail       (tail),
        .pay_raddr  (pay_raddr),
        .len_raddr  (len_raddr),
        .pay_rdata  (pay_rdata),
        .len_rdata  (len_rdata),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_data   (result.data),
        .stat       (stat)
    );

    prb_ram #(
        .WIDTH (8),
        .DEPTH (PAY_DEPTH)
    ) u_pay_ram (
        .clk     (clk),
        .wr_en   (pay_wr.en),
        .wr_addr (pay_wr.addr),
        .wr_data (pay_wr.data),
        .rd_addr (pay_raddr),
        .rd_data (pay_rdata)
    );

    prb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (len_wr.en),
        .wr_addr (len_wr.addr),
        .wr_data (len_wr.data),
        .rd_addr (len_raddr),
        .rd_data (len_rdata)
    );

endmodule

/* src/prb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the payload store and the slot length table.
`timescale 1ns / 1ps

module prb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/prb_wr_ctrl.sv */
// Write side: drop decision, length saturation, payload and length writes.
// Depends on prb_pkg.
`timescale 1ns / 1ps

module prb_wr_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push_fire,
    input  logic [7:0]                byte_value,
    input  logic                      last_byte,
    input  logic [prb_pkg::SLOT_W-1:0] tail,
    output logic [prb_pkg::SLOT_W-1:0] head,
    output prb_pkg::pay_wr_t          pay_wr,
    output prb_pkg::len_wr_t          len_wr
);
    import prb_pkg::*;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  wc_reg, wc_next;
    logic              drop_reg, drop_next;
    logic              full, drop_now, room;
    logic [CNT_W-1:0]  wc_inc;

    always_comb
    begin
        full     = (next_slot(head_reg) == tail);
        // The drop decision is made only on the first beat of a packet.
        drop_now = drop_reg || ((wc_reg == '0) && full);
        room     = (wc_reg < CNT_W'(SLOT_BYTES));
        wc_inc   = room ? (wc_reg + 1'b1) : wc_reg;

        pay_wr.en   = push_fire && !drop_now && room;
        pay_wr.addr = {head_reg, wc_reg[IDX_W-1:0]};
        pay_wr.data = byte_value;

        len_wr.en   = push_fire && !drop_now && last_byte;
        len_wr.addr = head_reg;
        len_wr.data = wc_inc;

        head_next = head_reg;
        wc_next   = wc_reg;
        drop_next = drop_reg;
        if (push_fire)
        begin
            if (drop_now)
            begin
                drop_next = !last_byte;
            end
            else if (last_byte)
            begin
                head_next = next_slot(head_reg);
                wc_next   = '0;
            end
            else
            begin
                wc_next = wc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            wc_reg   <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            wc_reg   <= wc_next;
            drop_reg <= drop_next;
        end
    end

    assign head = head_reg;

endmodule

/* src/prb_rd_ctrl.sv */
// Read side: issues payload and length reads, forms the popped beat and
// advances the tail. Depends on prb_pkg.
`timescale 1ns / 1ps

module prb_rd_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_fire,
    input  logic [prb_pkg::LIM_W-1:0]  read_limit,
    input  logic [prb_pkg::SLOT_W-1:0] head,
    output logic [prb_pkg::SLOT_W-1:0] tail,
    output logic [prb_pkg::PAY_AW-1:0] pay_raddr,
    output logic [prb_pkg::SLOT_W-1:0] len_raddr,
    input  logic [7:0]                 pay_rdata,
    input  logic [prb_pkg::CNT_W-1:0]  len_rdata,
    input  logic                       out_ready,
    output logic                       out_valid,
    output prb_pkg::result_t           out_data,
    output prb_pkg::rd_stat_t          stat
);
    import prb_pkg::*;

    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  rc_reg, rc_next;
    logic [LIM_W-1:0]  lim_reg, lim_next;
    logic              pend_reg, pend_next;
    logic              oval_reg, oval_next;
    result_t           res_reg, res_next;

    logic              empty, eop;
    logic [IDX_W-1:0]  idx;
    logic [CMP_W-1:0]  lim_eff, len_ext, n;
    logic [CMP_W:0]    rc_plus;

    // Reads go out every cycle from the current tail and count; the data is
    // used in the cycle after a pop is taken, and no write can touch the
    // stored packet at the tail in between.
    always_comb
    begin
        if (rc_reg >= CNT_W'(SLOT_BYTES))
            idx = IDX_W'(SLOT_BYTES - 1);
        else
            idx = rc_reg[IDX_W-1:0];
    end

    assign pay_raddr = {tail_reg, idx};
    assign len_raddr = tail_reg;

    always_comb
    begin
        empty   = (head == tail_reg);
        lim_eff = (lim_reg == '0) ? CMP_W'(1) : CMP_W'(lim_reg);
        len_ext = CMP_W'(len_rdata);
        n       = (lim_eff < len_ext) ? lim_eff : len_ext;
        rc_plus = (CMP_W + 1)'(rc_reg) + 1'b1;
        eop     = (rc_plus >= {1'b0, n});

        pend_next = pop_fire;
        lim_next  = pop_fire ? read_limit : lim_reg;
        tail_next = tail_reg;
        rc_next   = rc_reg;
        res_next  = res_reg;
        oval_next = oval_reg && !out_ready;

        if (pend_reg)
        begin
            oval_next = 1'b1;
            if (empty)
            begin
                res_next.status        = STATUS_EMPTY;
                res_next.out_byte      = '0;
                res_next.end_of_packet = 1'b0;
            end
            else
            begin
                res_next.status        = STATUS_VALID;
                res_next.out_byte      = pay_rdata;
                res_next.end_of_packet = eop;
                if (eop)
                begin
                    tail_next = next_slot(tail_reg);
                    rc_next   = '0;
                end
                else
                begin
                    rc_next = rc_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg <= '0;
            rc_reg   <= '0;
            lim_reg  <= '0;
            pend_reg <= 1'b0;
            oval_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            tail_reg <= tail_next;
            rc_reg   <= rc_next;
            lim_reg  <= lim_next;
            pend_reg <= pend_next;
            oval_reg <= oval_next;
            res_reg  <= res_next;
        end
    end

    assign tail          = tail_reg;
    assign out_valid     = oval_reg;
    assign out_data      = res_reg;
    assign stat.busy     = pend_reg;
    assign stat.out_full = oval_reg && !out_ready;

endmodule

/* src/prb_checker.sv */
// Port-level assertions for the packet ring buffer, attached by bind.
// Depends on prb_pkg and the top level packet_ring_buffer.
`timescale 1ns / 1ps

module prb_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input prb_pkg::kind_t   item_kind,
    input logic             result_valid,
    input logic             result_ready,
    input prb_pkg::result_t result_data
);
    import prb_pkg::*;

    logic pop_taken;
    assign pop_taken = item_valid && item_ready && (item_kind == KIND_POP);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_data))
        else $error("result payload changed while stalled");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop_taken |=> ##1 result_valid)
        else $error("pop beat produced no result");

    a_pop_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        pop_taken |=> !item_ready)
        else $error("item taken while a pop read was in flight");

    a_empty_format: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.status == STATUS_EMPTY)
            |-> (result_data.out_byte == 8'd0) && !result_data.end_of_packet)
        else $error("empty result carries data");

endmodule

bind packet_ring_buffer prb_checker u_prb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_kind    (item.data.kind),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
